// ===== src/depq_pkg.sv =====
`default_nettype none

package depq_pkg;

	// Field widths
	localparam int ID_W   = 24;
	localparam int PRI_W  = 24;
	localparam int KEY_W  = PRI_W + ID_W;
	localparam int OP_W   = 2;
	localparam int ST_W   = 2;
	localparam int OCC_W  = 11;

	// Tail-id reduction tree: fan-in per node and number of registered levels
	localparam int FAN      = 32;
	localparam int TREE_LAT = 4;
	localparam int SET_W    = $clog2(TREE_LAT + 1);

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_REM_MAX = 2'd1;
	localparam logic [OP_W-1:0] OP_REM_MIN = 2'd2;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// Command broadcast to every cell
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REM_MAX,
		CELL_REM_MIN
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [KEY_W-1:0] key;
	} cell_cmd_t;

	// What a cell shows to its neighbors
	typedef struct packed {
		logic             valid;
		logic             place;
		logic [KEY_W-1:0] key;
	} cell_link_t;

endpackage

`default_nettype wire

// ===== src/depq_req_if.sv =====
`default_nettype none

interface depq_req_if;
	logic                        valid;
	logic                        ready;
	logic [depq_pkg::OP_W-1:0]   operation;
	logic [depq_pkg::ID_W-1:0]   client_id;
	logic [depq_pkg::PRI_W-1:0]  entry_priority;

	modport source (output valid, output operation, output client_id,
		output entry_priority, input ready);
	modport sink (input valid, input operation, input client_id,
		input entry_priority, output ready);
endinterface

`default_nettype wire

// ===== src/depq_rsp_if.sv =====
`default_nettype none

interface depq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [depq_pkg::ID_W-1:0]   removed_id;
	logic [depq_pkg::ST_W-1:0]   status;
	logic [depq_pkg::OCC_W-1:0]  occupancy;

	modport source (output valid, output removed_id, output status,
		output occupancy, input ready);
	modport sink (input valid, input removed_id, input status,
		input occupancy, output ready);
endinterface

`default_nettype wire

// ===== src/double_ended_priority_queue.sv =====
`default_nettype none

// Channel  Dir  Fields                                        Accepted when
// req      in   operation, client_id, entry_priority          req.valid && req.ready
// rsp      out  removed_id, status, occupancy                 rsp.valid && rsp.ready
//
// Entries sit sorted ascending in a row of cells, smallest in cell 0.
// Inserts and remove-min can follow every cycle while the result register is free.
// Remove-max reads the last occupied cell through a 4-level registered
// reduction tree, so it waits for the tree to settle after the last change.
// Reset clears the cell valid bits and the count; no clearing pass.
// A full result register stalls execution; one item waits in the hold register.

module double_ended_priority_queue #(
	parameter int CAPACITY = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	depq_req_if.sink        req,
	depq_rsp_if.source      rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int N1 = (CAPACITY + depq_pkg::FAN - 1) / depq_pkg::FAN;
	localparam int N2 = (N1 + depq_pkg::FAN - 1) / depq_pkg::FAN;
	localparam int N3 = (N2 + depq_pkg::FAN - 1) / depq_pkg::FAN;
	localparam int N4 = (N3 + depq_pkg::FAN - 1) / depq_pkg::FAN;

	// Hold register for the accepted word
	logic                             pend_q;
	logic [depq_pkg::OP_W-1:0]        op_q;
	logic [depq_pkg::ID_W-1:0]        id_q;
	logic [depq_pkg::PRI_W-1:0]       pri_q;

	logic [CNT_W-1:0]                 count_q;
	logic [CNT_W-1:0]                 count_d;
	logic [depq_pkg::SET_W-1:0]       settle_q;

	logic                             out_valid_q;
	logic [depq_pkg::ID_W-1:0]        out_id_q;
	logic [depq_pkg::ST_W-1:0]        out_st_q;
	logic [depq_pkg::OCC_W-1:0]       out_occ_q;

	logic                             out_free;
	logic                             exec;
	logic                             changed;
	logic [depq_pkg::ID_W-1:0]        res_id;
	logic [depq_pkg::ST_W-1:0]        res_st;

	depq_pkg::cell_cmd_t              cell_cmd;
	depq_pkg::cell_link_t             link [CAPACITY];
	logic [CAPACITY-1:0][depq_pkg::ID_W-1:0] tails;
	logic [CAPACITY-1:0]              valid_vec;

	logic [N1-1:0][depq_pkg::ID_W-1:0] lvl1;
	logic [N2-1:0][depq_pkg::ID_W-1:0] lvl2;
	logic [N3-1:0][depq_pkg::ID_W-1:0] lvl3;
	logic [N4-1:0][depq_pkg::ID_W-1:0] lvl4;

	// Execute when the result slot frees; remove-max also waits for the tree
	assign out_free = !out_valid_q || rsp.ready;
	assign exec = pend_q && out_free
		&& ((op_q != depq_pkg::OP_REM_MAX) || (settle_q == '0));
	assign req.ready = !pend_q || exec;

	// Row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		depq_pkg::cell_link_t prev_l;
		depq_pkg::cell_link_t next_l;

		if (i == 0) begin : g_first
			assign prev_l = '0;
		end else begin : g_mid_prev
			assign prev_l = link[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_l = '0;
		end else begin : g_mid_next
			assign next_l = link[i+1];
		end

		depq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cell_cmd),
			.prev    (prev_l),
			.next    (next_l),
			.self    (link[i]),
			.tail_id (tails[i])
		);

		assign valid_vec[i] = link[i].valid;
	end

	// Reduce the one-hot tail ids to the id of the largest entry
	depq_or_tree #(.N_IN(CAPACITY)) u_tree1 (.clk(clk), .leaf(tails), .node_q(lvl1));
	depq_or_tree #(.N_IN(N1))       u_tree2 (.clk(clk), .leaf(lvl1),  .node_q(lvl2));
	depq_or_tree #(.N_IN(N2))       u_tree3 (.clk(clk), .leaf(lvl2),  .node_q(lvl3));
	depq_or_tree #(.N_IN(N3))       u_tree4 (.clk(clk), .leaf(lvl3),  .node_q(lvl4));

	// Decode the held word into a cell command and a result
	always_comb begin
		cell_cmd.op  = depq_pkg::CELL_HOLD;
		cell_cmd.key = {pri_q, id_q};
		res_id  = '0;
		res_st  = depq_pkg::ST_OK;
		count_d = count_q;
		changed = 1'b0;
		if (exec) begin
			unique case (op_q)
				depq_pkg::OP_INSERT: begin
					if (count_q == CNT_W'(CAPACITY)) begin
						res_st = depq_pkg::ST_FULL;
					end else begin
						cell_cmd.op = depq_pkg::CELL_INSERT;
						count_d = count_q + 1'b1;
						changed = 1'b1;
					end
				end
				depq_pkg::OP_REM_MAX: begin
					if (count_q == '0) begin
						res_st = depq_pkg::ST_EMPTY;
					end else begin
						cell_cmd.op = depq_pkg::CELL_REM_MAX;
						res_id  = lvl4[0];
						count_d = count_q - 1'b1;
						changed = 1'b1;
					end
				end
				depq_pkg::OP_REM_MIN: begin
					if (count_q == '0) begin
						res_st = depq_pkg::ST_EMPTY;
					end else begin
						cell_cmd.op = depq_pkg::CELL_REM_MIN;
						res_id  = link[0].key[depq_pkg::ID_W-1:0];
						count_d = count_q - 1'b1;
						changed = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			count_q     <= '0;
			settle_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				pend_q <= 1'b1;
			end else if (exec) begin
				pend_q <= 1'b0;
			end
			count_q <= count_d;
			if (changed) begin
				settle_q <= depq_pkg::SET_W'(depq_pkg::TREE_LAT);
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.operation;
			id_q  <= req.client_id;
			pri_q <= req.entry_priority;
		end
		if (exec) begin
			out_id_q  <= res_id;
			out_st_q  <= res_st;
			out_occ_q <= depq_pkg::OCC_W'(count_d);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.removed_id = out_id_q;
	assign rsp.status     = out_st_q;
	assign rsp.occupancy  = out_occ_q;

	// Occupied cells form a prefix whose length is the count
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == count_q)
		else $error("cell valid bits disagree with count");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		valid_vec[0] == (count_q != '0))
		else $error("first cell empty while queue holds entries");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q == depq_pkg::ST_EMPTY) |-> (out_occ_q == '0))
		else $error("empty status with nonzero occupancy");

	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && op_q == depq_pkg::OP_INSERT && count_q != CNT_W'(CAPACITY))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("accepted insert did not grow the queue");

endmodule

`default_nettype wire

// ===== src/depq_cell.sv =====
`default_nettype none

module depq_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire depq_pkg::cell_cmd_t   cmd,
	input  wire depq_pkg::cell_link_t  prev,
	input  wire depq_pkg::cell_link_t  next,
	output depq_pkg::cell_link_t       self,
	output logic [depq_pkg::ID_W-1:0]  tail_id
);

	logic                        valid_q;
	logic [depq_pkg::KEY_W-1:0]  key_q;
	logic                        place;
	logic                        valid_d;
	logic [depq_pkg::KEY_W-1:0]  key_d;

	// An insert lands here or further left when this slot is empty or larger
	assign place = !valid_q || (key_q > cmd.key);

	assign self.valid = valid_q;
	assign self.place = place;
	assign self.key   = key_q;

	// Offer the id only when this is the last occupied cell
	assign tail_id = (valid_q && !next.valid) ? key_q[depq_pkg::ID_W-1:0] : '0;

	// Select the next contents from the broadcast command
	always_comb begin
		valid_d = valid_q;
		key_d   = key_q;
		unique case (cmd.op)
			depq_pkg::CELL_INSERT: begin
				if (prev.place) begin
					valid_d = prev.valid;
					key_d   = prev.key;
				end else if (place) begin
					valid_d = 1'b1;
					key_d   = cmd.key;
				end
			end
			depq_pkg::CELL_REM_MAX: begin
				valid_d = valid_q && next.valid;
			end
			depq_pkg::CELL_REM_MIN: begin
				valid_d = next.valid;
				key_d   = next.key;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

endmodule

`default_nettype wire

// ===== src/depq_or_tree.sv =====
`default_nettype none

module depq_or_tree #(
	parameter int N_IN = 1024
) (
	input  wire logic                                   clk,
	input  wire logic [N_IN-1:0][depq_pkg::ID_W-1:0]    leaf,
	output logic [((N_IN + depq_pkg::FAN - 1) / depq_pkg::FAN)-1:0]
		[depq_pkg::ID_W-1:0]                            node_q
);

	localparam int N_OUT = (N_IN + depq_pkg::FAN - 1) / depq_pkg::FAN;

	// Merge each group of one-hot ids into one registered node
	for (genvar g = 0; g < N_OUT; g++) begin : g_node
		localparam int LO  = g * depq_pkg::FAN;
		localparam int CNT = (N_IN - LO < depq_pkg::FAN) ? (N_IN - LO) : depq_pkg::FAN;
		logic [depq_pkg::ID_W-1:0] acc;

		always_comb begin
			acc = '0;
			for (int k = 0; k < CNT; k++) begin
				acc = acc | leaf[LO + k];
			end
		end

		always_ff @(posedge clk) begin
			node_q[g] <= acc;
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH = 1024;
	localparam int N_DIRECTED = 25;
	// Operation code 3 is not a real command: the queue must ignore it
	localparam logic [depq_pkg::OP_W-1:0] OP_IGNORED = 2'd3;

	typedef struct packed {
		logic [depq_pkg::ID_W-1:0]  removed_id;
		logic [depq_pkg::ST_W-1:0]  status;
		logic [depq_pkg::OCC_W-1:0] occupancy;
	} outcome_t;

	typedef struct packed {
		logic [depq_pkg::OP_W-1:0]  op;
		logic [depq_pkg::ID_W-1:0]  id;
		logic [depq_pkg::PRI_W-1:0] pri;
		logic                       pinned;
		outcome_t                   want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	depq_req_if req_ch ();
	depq_rsp_if rsp_ch ();

	double_ended_priority_queue #(
		.CAPACITY(DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow of the queue contents, sorted ascending by {priority, id}
	logic [depq_pkg::KEY_W-1:0] sorted_keys[$];
	outcome_t                   owed_results[$];
	int                         fault_count = 0;

	// Sideband for directed rows whose result is typed in the table
	logic     pinned_now;
	outcome_t pinned_want;

	// Idling controls
	bit gaps_on = 1'b1;
	bit quiet = 1'b0;

	// Directed rows: empty removals, ignored code, extremes, duplicates, equal priorities
	stim_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{depq_pkg::OP_REM_MAX, 24'h000000, 24'h000000,
			1'b1, '{24'h000000, depq_pkg::ST_EMPTY, 11'd0}},
		'{depq_pkg::OP_REM_MIN, 24'h000000, 24'h000000,
			1'b1, '{24'h000000, depq_pkg::ST_EMPTY, 11'd0}},
		'{OP_IGNORED, 24'hFFFFFF, 24'hFFFFFF,
			1'b1, '{24'h000000, depq_pkg::ST_OK, 11'd0}},
		'{depq_pkg::OP_INSERT, 24'hFFFFFF, 24'hFFFFFF,
			1'b1, '{24'h000000, depq_pkg::ST_OK, 11'd1}},
		'{depq_pkg::OP_INSERT, 24'h000000, 24'h000000,
			1'b1, '{24'h000000, depq_pkg::ST_OK, 11'd2}},
		'{depq_pkg::OP_INSERT, 24'h000123, 24'h000000,
			1'b1, '{24'h000000, depq_pkg::ST_OK, 11'd3}},
		'{depq_pkg::OP_INSERT, 24'h000000, 24'hFFFFFF,
			1'b1, '{24'h000000, depq_pkg::ST_OK, 11'd4}},
		'{depq_pkg::OP_REM_MAX, 24'h000000, 24'h000000,
			1'b1, '{24'hFFFFFF, depq_pkg::ST_OK, 11'd3}},
		'{depq_pkg::OP_REM_MIN, 24'h000000, 24'h000000,
			1'b1, '{24'h000000, depq_pkg::ST_OK, 11'd2}},
		'{depq_pkg::OP_INSERT,  24'h000010, 24'h000500, 1'b0, '0},
		'{depq_pkg::OP_INSERT,  24'h000010, 24'h000500, 1'b0, '0},
		'{depq_pkg::OP_INSERT,  24'h000008, 24'h000500, 1'b0, '0},
		'{depq_pkg::OP_INSERT,  24'hABCDEF, 24'h000500, 1'b0, '0},
		'{depq_pkg::OP_REM_MIN, 24'h000000, 24'h000000, 1'b0, '0},
		'{depq_pkg::OP_REM_MIN, 24'h000000, 24'h000000, 1'b0, '0},
		'{depq_pkg::OP_REM_MAX, 24'h000000, 24'h000000, 1'b0, '0},
		'{depq_pkg::OP_REM_MAX, 24'h000000, 24'h000000, 1'b0, '0},
		'{depq_pkg::OP_REM_MAX, 24'h000000, 24'h000000, 1'b0, '0},
		'{depq_pkg::OP_REM_MIN, 24'h000000, 24'h000000, 1'b0, '0},
		'{depq_pkg::OP_REM_MIN, 24'h000000, 24'h000000,
			1'b1, '{24'h000000, depq_pkg::ST_EMPTY, 11'd0}},
		'{depq_pkg::OP_INSERT,  24'hAAAAAA, 24'h555555, 1'b0, '0},
		'{depq_pkg::OP_INSERT,  24'h555555, 24'hAAAAAA, 1'b0, '0},
		'{OP_IGNORED,           24'h123456, 24'h654321, 1'b0, '0},
		'{depq_pkg::OP_REM_MAX, 24'h000000, 24'h000000, 1'b0, '0},
		'{depq_pkg::OP_REM_MIN, 24'h000000, 24'h000000, 1'b0, '0}
	};

	// Apply one command to the shadow queue and return the result it owes
	function automatic outcome_t apply_command(logic [depq_pkg::OP_W-1:0] op,
			logic [depq_pkg::ID_W-1:0] id, logic [depq_pkg::PRI_W-1:0] pri);
		outcome_t                   res;
		logic [depq_pkg::KEY_W-1:0] key;
		int                         slot;
		res = '0;
		res.status = depq_pkg::ST_OK;
		key = {pri, id};
		case (op) inside
			depq_pkg::OP_INSERT: begin
				if (sorted_keys.size() >= DEPTH) begin
					res.status = depq_pkg::ST_FULL;
				end else begin
					// place after every entry that is not greater
					slot = 0;
					while (slot < sorted_keys.size() && sorted_keys[slot] <= key)
						slot++;
					sorted_keys.insert(slot, key);
				end
			end
			depq_pkg::OP_REM_MAX, depq_pkg::OP_REM_MIN: begin
				if (sorted_keys.size() == 0) begin
					res.status = depq_pkg::ST_EMPTY;
				end else if (op == depq_pkg::OP_REM_MAX) begin
					key = sorted_keys.pop_back();
					res.removed_id = key[depq_pkg::ID_W-1:0];
				end else begin
					key = sorted_keys.pop_front();
					res.removed_id = key[depq_pkg::ID_W-1:0];
				end
			end
			default: begin
			end
		endcase
		res.occupancy = depq_pkg::OCC_W'(sorted_keys.size());
		return res;
	endfunction

	// Mix of extremes, a narrow range for collisions, and full-range values
	function automatic logic [23:0] pick_value();
		logic [23:0] v;
		case ($urandom_range(0, 9))
			0: v = 24'h000000;
			1: v = 24'hFFFFFF;
			2, 3, 4: v = 24'($urandom_range(0, 7));
			default: v = 24'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [depq_pkg::OP_W-1:0] pick_op(int insert_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < insert_pct)
			return depq_pkg::OP_INSERT;
		return (r % 2) ? depq_pkg::OP_REM_MAX : depq_pkg::OP_REM_MIN;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reset and known input values from time zero
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = depq_pkg::OP_INSERT;
		req_ch.client_id = '0;
		req_ch.entry_priority = '0;
		rsp_ch.ready = 1'b0;
		pinned_now = 1'b0;
		pinned_want = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Result side: accept with random stall bursts
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Predict on every accepted command, check every accepted result
	always @(posedge clk) begin
		outcome_t predicted;
		outcome_t owed;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				predicted = apply_command(req_ch.operation, req_ch.client_id,
					req_ch.entry_priority);
				owed_results.push_back(pinned_now ? pinned_want : predicted);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (owed_results.size() == 0) begin
					$error("unexpected result word: removed_id %0h status %0d occupancy %0d",
						rsp_ch.removed_id, rsp_ch.status, rsp_ch.occupancy);
					fault_count++;
				end else begin
					owed = owed_results.pop_front();
					if (rsp_ch.removed_id !== owed.removed_id) begin
						$error("removed_id expected %0h actual %0h",
							owed.removed_id, rsp_ch.removed_id);
						fault_count++;
					end
					if (rsp_ch.status !== owed.status) begin
						$error("status expected %0d actual %0d", owed.status, rsp_ch.status);
						fault_count++;
					end
					if (rsp_ch.occupancy !== owed.occupancy) begin
						$error("occupancy expected %0d actual %0d",
							owed.occupancy, rsp_ch.occupancy);
						fault_count++;
					end
				end
			end
		end
	end

	// Drive one command word and hold it until accepted; called at a falling edge
	task automatic send_word(logic [depq_pkg::OP_W-1:0] op, logic [depq_pkg::ID_W-1:0] id,
			logic [depq_pkg::PRI_W-1:0] pri, logic pinned, outcome_t want);
		if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.client_id <= id;
		req_ch.entry_priority <= pri;
		pinned_now <= pinned;
		pinned_want <= want;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold off the sender until every owed result has come back
	task automatic await_drain();
		req_ch.valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stimulus
	initial begin
		int n;
		@(posedge arst_n);
		@(negedge clk);

		// directed table
		for (int i = 0; i < N_DIRECTED; i++)
			send_word(directed_rows[i].op, directed_rows[i].id, directed_rows[i].pri,
				directed_rows[i].pinned, directed_rows[i].want);
		await_drain();

		// churn near empty
		for (n = 0; n < 40; n++) begin
			if (n % 40 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			send_word(pick_op(45), pick_value(), pick_value(), 1'b0, '0);
		end

		// fill to capacity
		n = 0;
		while (sorted_keys.size() < DEPTH) begin
			if (n % 40 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			send_word(pick_op(100), pick_value(), pick_value(), 1'b0, '0);
			n++;
		end
		await_drain();

		// sit at full: dropped inserts mixed with removals
		for (n = 0; n < 30; n++)
			send_word(pick_op(70), pick_value(), pick_value(), 1'b0, '0);

		// drain partway with mostly removals
		for (n = 0; n < 40; n++) begin
			if (n % 40 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			send_word(pick_op(15), pick_value(), pick_value(), 1'b0, '0);
		end

		// final stretch with no idling on either side
		quiet = 1'b1;
		for (n = 0; n < 40; n++)
			send_word(pick_op(40), pick_value(), pick_value(), 1'b0, '0);

		req_ch.valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("double_ended_priority_queue verification clean");
		else
			$display("double_ended_priority_queue verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("double_ended_priority_queue verification failed");
		$finish;
	end

endmodule
